### src/mtprt_pkg.sv
// package: widths, types and the tree node function of the pair reduction tree
`default_nettype none

package mtprt_pkg;

    localparam int NUM_BOARDS    = 16;
    localparam int WORD_BITS     = 6;
    localparam int NUM_MASK_REGS = NUM_BOARDS / 2;
    localparam int MASK_W        = 2 * WORD_BITS;
    localparam int LOCAL_W       = (NUM_BOARDS / 2) * WORD_BITS;
    localparam int DECISION_W    = 12;
    localparam int NUM_THRESH    = 3;
    localparam int CFG_IDX_W     = $clog2(NUM_MASK_REGS) + 1;
    localparam int MASK_SEL_W    = $clog2(NUM_MASK_REGS);

    localparam logic [MASK_W-1:0] MASK_RESET = '1;

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [DECISION_W-1:0] t_nibbles;
    typedef logic [NUM_MASK_REGS-1:0][MASK_W-1:0] t_mask_bank;

    // one tree node; first selects level 0 pair layout
    function automatic t_nibbles tree_node(input t_nibbles a, input t_nibbles b,
                                           input logic first);
        t_nibbles res;
        logic a0, a1, b0, b1, ls_in, us_in, ls, us;
        res = '0;
        for (int k = 0; k < NUM_THRESH; k++) begin
            if (first) begin
                a0 = a[2*k];
                a1 = a[2*k+1];
                b0 = b[2*k];
                b1 = b[2*k+1];
                ls_in = 1'b0;
                us_in = 1'b0;
            end else begin
                a0 = a[4*k+2];
                a1 = a[4*k+3];
                b0 = b[4*k+2];
                b1 = b[4*k+3];
                ls_in = a[4*k+1] | b[4*k+1];
                us_in = a[4*k] | b[4*k];
            end
            ls = (a0 & b0) | (a1 & b1) | ls_in;
            us = (a0 & b1) | (a1 & b0) | us_in;
            res[4*k +: 4] = {a1 | b1, a0 | b0, ls, us};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/mtprt_tree.sv
// masking of the local words and the four-level pair reduction tree
`default_nettype none

module mtprt_tree
    import mtprt_pkg::*;
(
    input  wire logic [LOCAL_W-1:0]    i_words_low,
    input  wire logic [LOCAL_W-1:0]    i_words_high,
    input  wire t_mask_bank            i_masks,
    output logic      [DECISION_W-1:0] o_decision
);

    logic [2*LOCAL_W-1:0]              words;
    t_nibbles [NUM_BOARDS-1:0]         lvl0;
    t_nibbles [NUM_BOARDS/2-1:0]       lvl1;
    t_nibbles [NUM_BOARDS/4-1:0]       lvl2;
    t_nibbles [NUM_BOARDS/8-1:0]       lvl3;
    t_nibbles                          lvl4;

    assign words = {i_words_high, i_words_low};

    always_comb begin
        for (int b = 0; b < NUM_BOARDS; b++) begin
            lvl0[b] = t_nibbles'(words[WORD_BITS*b +: WORD_BITS]
                      & i_masks[b/2][WORD_BITS*(b%2) +: WORD_BITS]);
        end
        for (int j = 0; j < NUM_BOARDS/2; j++) begin
            lvl1[j] = tree_node(lvl0[2*j], lvl0[2*j+1], 1'b1);
        end
        for (int j = 0; j < NUM_BOARDS/4; j++) begin
            lvl2[j] = tree_node(lvl1[2*j], lvl1[2*j+1], 1'b0);
        end
        for (int j = 0; j < NUM_BOARDS/8; j++) begin
            lvl3[j] = tree_node(lvl2[2*j], lvl2[2*j+1], 1'b0);
        end
        lvl4 = tree_node(lvl3[0], lvl3[1], 1'b0);
    end

    assign o_decision = lvl4;

endmodule

`default_nettype wire

### src/muon_trigger_pair_reduction_tree_unit.sv
// top level: mask registers, input register, reduction tree and result register
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_local_words_low, i_local_words_high
//   out      output     o_out_valid / i_out_ready  o_regional_decision
//   cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// an accepted item passes through the input register, then the result register, to its result
// one item per cycle sustained while the output is not stalled; the tree sits between the two registers
// reset is synchronous and clears the valid flags and sets all masks to ones
// a stalled output stage holds its item; the input stage fills behind it, then ready drops
`default_nettype none

module muon_trigger_pair_reduction_tree_unit
    import mtprt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [LOCAL_W-1:0]    i_local_words_low,
    input  wire logic [LOCAL_W-1:0]    i_local_words_high,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [DECISION_W-1:0] o_regional_decision,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [MASK_W-1:0]     i_cfg_data
);

    t_mask_bank               r_mask;
    logic                     r_in_valid;
    logic [LOCAL_W-1:0]       r_words_low;
    logic [LOCAL_W-1:0]       r_words_high;
    logic                     r_out_valid;
    logic [DECISION_W-1:0]    r_decision;
    logic [DECISION_W-1:0]    n_decision;
    logic                     out_take;

    // output stage can take a new item
    assign out_take   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_MASK_REGS; p++) begin
                r_mask[p] <= MASK_RESET;
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_MASK_REGS))) begin
            r_mask[i_cfg_index[MASK_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_words_low  <= i_local_words_low;
            r_words_high <= i_local_words_high;
        end
    end

    mtprt_tree u_tree (
        .i_words_low  (r_words_low),
        .i_words_high (r_words_high),
        .i_masks      (r_mask),
        .o_decision   (n_decision)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_in_valid) begin
            r_decision <= n_decision;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_regional_decision = r_decision;

`ifndef ASSERT_OFF
    a_in_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_in_valid)
        else $error("accepted item not held in input stage");

    a_out_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_take |=> o_out_valid)
        else $error("input stage item did not reach result register");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_take |=> r_in_valid && $stable(r_words_low)
                                    && $stable(r_words_high))
        else $error("input stage item lost during output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

### sim/tb_muon_trigger_pair_reduction_tree_unit.sv
// testbench: masked pair reduction tree checked against a predicted decision per item
module tb_muon_trigger_pair_reduction_tree_unit;
    import mtprt_pkg::*;

    localparam int BOARD_SET_W    = 2 * LOCAL_W;
    localparam int MAX_SEND_GAP   = 40;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTED    = 100;
    localparam int NUM_PHASES     = 6;

    // nibble bit positions
    localparam int NIB_UNLIKE = 0;
    localparam int NIB_LIKE   = 1;
    localparam int NIB_OR0    = 2;
    localparam int NIB_OR1    = 3;

    typedef logic [BOARD_SET_W-1:0] t_board_set;
    typedef enum int {MASKS_ONES, MASKS_ZERO, MASKS_RANDOM, MASKS_MIXED} t_mask_style;

    logic                  i_clk;
    logic                  i_rst_n             = 1'b0;
    logic                  i_in_valid          = 1'b0;
    logic                  o_in_ready;
    logic [LOCAL_W-1:0]    i_local_words_low   = '0;
    logic [LOCAL_W-1:0]    i_local_words_high  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready         = 1'b0;
    logic [DECISION_W-1:0] o_regional_decision;
    logic                  i_cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index         = '0;
    logic [MASK_W-1:0]     i_cfg_data          = '0;

    class decision_scoreboard;
        t_mask_bank masks;
        t_nibbles   expected_decisions[$];
        int         errors;
        int         checked_count;

        function new();
            masks = {NUM_MASK_REGS{MASK_RESET}};
            errors = 0;
            checked_count = 0;
        endfunction

        function void write_mask(int index, logic [MASK_W-1:0] data);
            if (index < NUM_MASK_REGS) begin
                masks[index] = data;
            end
        endfunction

        function logic [3:0] merge_pair(logic [3:0] a, logic [3:0] b);
            logic [3:0] nib;
            nib[NIB_OR1]    = a[NIB_OR1] | b[NIB_OR1];
            nib[NIB_OR0]    = a[NIB_OR0] | b[NIB_OR0];
            nib[NIB_LIKE]   = (a[NIB_OR0] & b[NIB_OR0]) | (a[NIB_OR1] & b[NIB_OR1])
                              | a[NIB_LIKE] | b[NIB_LIKE];
            nib[NIB_UNLIKE] = (a[NIB_OR0] & b[NIB_OR1]) | (a[NIB_OR1] & b[NIB_OR0])
                              | a[NIB_UNLIKE] | b[NIB_UNLIKE];
            return nib;
        endfunction

        // leaves carry the trigger pair with clear sign bits, so every level merges alike
        function t_nibbles predict_decision(t_board_set boards);
            logic [3:0] node [NUM_BOARDS][NUM_THRESH];
            t_word      w;
            int         width;
            for (int b = 0; b < NUM_BOARDS; b++) begin
                w = boards[WORD_BITS*b +: WORD_BITS]
                    & masks[b/2][WORD_BITS*(b%2) +: WORD_BITS];
                for (int k = 0; k < NUM_THRESH; k++) begin
                    node[b][k] = {w[2*k+1], w[2*k], 2'b00};
                end
            end
            width = NUM_BOARDS;
            while (width > 1) begin
                width = width / 2;
                for (int j = 0; j < width; j++) begin
                    for (int k = 0; k < NUM_THRESH; k++) begin
                        node[j][k] = merge_pair(node[2*j][k], node[2*j+1][k]);
                    end
                end
            end
            return {node[0][2], node[0][1], node[0][0]};
        endfunction

        function void note_item(t_board_set boards);
            expected_decisions.push_back(predict_decision(boards));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("mismatch: %s", msg);
            end
        endtask

        task check_decision(t_nibbles got);
            t_nibbles want;
            if (expected_decisions.size() == 0) begin
                report($sformatf("decision %03h with no item outstanding", got));
            end else begin
                want = expected_decisions.pop_front();
                checked_count++;
                if (got !== want) begin
                    report($sformatf("regional_decision got %03h want %03h", got, want));
                end
            end
        endtask
    endclass

    decision_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    muon_trigger_pair_reduction_tree_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_local_words_low   (i_local_words_low),
        .i_local_words_high  (i_local_words_high),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_regional_decision (o_regional_decision),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_decision(o_regional_decision);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d decisions outstanding", sb.expected_decisions.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task send_item(t_board_set boards);
        int gap;
        i_in_valid         <= 1'b1;
        i_local_words_low  <= boards[LOCAL_W-1:0];
        i_local_words_high <= boards[BOARD_SET_W-1:LOCAL_W];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(boards);
        items_sent++;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task wait_until_idle();
        i_in_valid <= 1'b0;
        while (sb.expected_decisions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes the whole bank, then every index past the bank, which must not alias
    task program_masks(t_mask_bank bank);
        logic [MASK_W-1:0] data;
        for (int index = 0; index < (1 << CFG_IDX_W); index++) begin
            if (index < NUM_MASK_REGS) begin
                data = bank[index];
            end else begin
                data = $urandom_range(1) ? '0 : MASK_W'($urandom);
            end
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(index);
            i_cfg_data  <= data;
            @(posedge i_clk);
            sb.write_mask(index, data);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_mask_bank make_masks(t_mask_style style);
        t_mask_bank bank;
        t_word      w;
        for (int b = 0; b < NUM_BOARDS; b++) begin
            case (style)
                MASKS_ONES:   w = '1;
                MASKS_ZERO:   w = '0;
                MASKS_RANDOM: w = t_word'($urandom);
                default: begin
                    case ($urandom_range(2))
                        0:       w = '1;
                        1:       w = '0;
                        default: w = t_word'($urandom);
                    endcase
                end
            endcase
            bank[b/2][WORD_BITS*(b%2) +: WORD_BITS] = w;
        end
        return bank;
    endfunction

    function automatic t_board_set on_board(int b, t_word w);
        return t_board_set'(w) << (WORD_BITS * b);
    endfunction

    // mostly sparse sets so that sign bits have to climb the tree
    function automatic t_board_set random_boards();
        t_board_set boards;
        int         density;
        density = $urandom_range(3);
        if (density == 0) begin
            boards = {$urandom, $urandom, $urandom};
        end else begin
            boards = '0;
            for (int b = 0; b < NUM_BOARDS; b++) begin
                if ($urandom_range(density * 3) == 0) begin
                    boards |= on_board(b, t_word'($urandom_range(1, 63)));
                end
            end
        end
        return boards;
    endfunction

    initial begin
        t_board_set  walking;
        t_mask_style phase_masks [NUM_PHASES];
        int          phase_items [NUM_PHASES];
        int          phase_send  [NUM_PHASES];
        int          phase_stall [NUM_PHASES];

        phase_masks = '{MASKS_ONES, MASKS_RANDOM, MASKS_ZERO, MASKS_MIXED,
                        MASKS_RANDOM, MASKS_MIXED};
        phase_items = '{100, 110, 40, 120, 110, 120};
        phase_send  = '{0, 74, 0, 38, 0, 74};
        phase_stall = '{0, 0, 74, 38, 0, 74};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items under the reset masks
        send_item('0);
        send_item('1);
        send_item(on_board(0, 6'b000001));
        send_item(on_board(15, 6'b100000));
        send_item(on_board(0, 6'b000001) | on_board(1, 6'b000001));
        send_item(on_board(0, 6'b000001) | on_board(1, 6'b000010));
        send_item(on_board(0, 6'b000100) | on_board(15, 6'b001000));
        send_item(on_board(7, 6'b100000) | on_board(8, 6'b100000));
        send_item(on_board(3, 6'b010101) | on_board(12, 6'b101010));
        send_item(on_board(0, 6'b000001) | on_board(2, 6'b000001));
        send_item(on_board(5, 6'b000010) | on_board(6, 6'b000001));
        send_item({LOCAL_W'(0), {LOCAL_W{1'b1}}});
        send_item({{LOCAL_W{1'b1}}, LOCAL_W'(0)});
        send_item({{NUM_BOARDS{6'b010101}}});
        send_item({{NUM_BOARDS/2{6'b000000, 6'b111111}}});
        send_item({{BOARD_SET_W/2{2'b10}}});
        walking = '0;
        for (int b = 0; b < NUM_BOARDS; b++) begin
            walking |= on_board(b, t_word'(1 << (b % WORD_BITS)));
        end
        send_item(walking);
        wait_until_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_masks(make_masks(phase_masks[p]));
            send_idle_pct = phase_send[p];
            stall_pct     = phase_stall[p];
            for (int n = 0; n < phase_items[p]; n++) begin
                send_item(random_boards());
            end
            wait_until_idle();
            send_idle_pct = 0;
            stall_pct     = 0;
        end

        $display("%0d items over %0d mask settings, %0d decisions checked, %0d errors",
                 items_sent, NUM_PHASES, sb.checked_count, sb.errors);
        $display("covered all-ones, all-zero, random and mixed masks with sender and sink gaps");
        if (sb.errors == 0 && sb.expected_decisions.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
